// ===== hw/rtl/speech_segment_tracker_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Speech segment tracker assertion macros
// Shared concurrent assertion forms used by the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef SPEECH_SEGMENT_TRACKER_UNIT_ASSERT_SVH
`define SPEECH_SEGMENT_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SST_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// Speech segment tracker package
// Transaction types, configuration layout, register indexes and defaults.
// ----------------------------------------------------------------------------
package sst_pkg;

    // default width of the position counter, fixed probability width
    localparam int POS_WIDTH_DEF  = 32;
    localparam int PROB_WIDTH_DEF = 16;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SAMPLES   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_SILENCE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_SILENCE_LONG = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_SPEECH       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_SPEECH       = 3'd5;

    // field widths
    localparam int THR_W    = 16;
    localparam int WIN_W    = 13;
    localparam int LEN_W    = 32;
    localparam int PROB_W   = PROB_WIDTH_DEF;
    localparam int SAMPLE_W = 32;

    // item modes
    localparam logic MODE_WINDOW = 1'b0;
    localparam logic MODE_END    = 1'b1;

    // configuration reset values
    localparam logic [THR_W-1:0] THRESHOLD_RST        = 16'd16384;
    localparam logic [WIN_W-1:0] WINDOW_SAMPLES_RST   = 13'd512;
    localparam logic [LEN_W-1:0] MIN_SILENCE_RST      = 32'd1600;
    localparam logic [LEN_W-1:0] MIN_SILENCE_LONG_RST = 32'd1568;
    localparam logic [LEN_W-1:0] MIN_SPEECH_RST       = 32'd4000;
    localparam logic [LEN_W-1:0] MAX_SPEECH_RST       = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [WIN_W-1:0] window_samples;
        logic [LEN_W-1:0] min_silence;
        logic [LEN_W-1:0] min_silence_long;
        logic [LEN_W-1:0] min_speech;
        logic [LEN_W-1:0] max_speech;
    } cfg_t;

    typedef struct packed {
        logic                mode;
        logic [PROB_W-1:0]   frame_prob;
        logic [SAMPLE_W-1:0] audio_length;
    } in_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] seg_start;
        logic [SAMPLE_W-1:0] seg_end;
    } out_item_t;

endpackage

// ===== hw/rtl/speech_segment_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// Speech segment tracker
// Turns per-window speech probabilities into start/end sample segments.
// ----------------------------------------------------------------------------
//  channel   direction  ports                      payload
//  s_        in         s_valid s_ready s_item     mode, frame_prob, audio_length
//  m_        out        m_valid m_ready m_item     seg_start, seg_end
//  cfg_      in         cfg_we cfg_index cfg_wdata register writes, no read-back
//
//  One transaction per cycle unless a held result stalls; an item waits in the
//  input register, its result in the result register. The rate is set by the
//  single decision step between them, which also updates all segment state.
//  aresetn is synchronous, active low; it clears state and restores defaults.
//  A held result stalls the decision step; s_ready drops only when the input
//  register is full and the result register cannot be emptied.
// ----------------------------------------------------------------------------
module speech_segment_tracker_unit
    import sst_pkg::*;
#(
    parameter int POS_WIDTH  = POS_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_item,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t      cfg;
    logic      in_valid_reg,  in_valid_next;
    in_item_t  in_item_reg,   in_item_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg,  out_item_next;
    logic      step;
    logic      hit;
    out_item_t result;

    sst_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sst_track #(
        .POS_WIDTH  (POS_WIDTH)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .cfg     (cfg),
        .hit     (hit),
        .result  (result)
    );

    // process when an item is held and the result slot is free or draining
    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    // input register
    always_comb begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
            in_item_next  = s_item;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (step) begin
            out_valid_next = hit;
            if (hit) begin
                out_item_next = result;
            end
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

`include "speech_segment_tracker_unit_assert.svh"

    // a pending result only goes away once it was taken
    `SST_ASSERT_NEXT(a_result_kept, aclk, aresetn, out_valid_reg && !m_ready, out_valid_reg, "pending result lost")
    // a pending result keeps its payload until taken
    `SST_ASSERT_NEXT(a_result_stable, aclk, aresetn, out_valid_reg && !m_ready, $stable(out_item_reg), "pending result changed")
    // an empty input register always accepts
    `SST_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !in_valid_reg, s_ready, "input refused while empty")

endmodule

// ===== hw/rtl/sst_cfg.sv =====
// ----------------------------------------------------------------------------
// Speech segment tracker configuration registers
// Write-only register file holding thresholds and timing limits.
// ----------------------------------------------------------------------------
module sst_cfg
    import sst_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode, unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_THRESHOLD:        cfg_next.threshold        = cfg_wdata[THR_W-1:0];
                REG_WINDOW_SAMPLES:   cfg_next.window_samples   = cfg_wdata[WIN_W-1:0];
                REG_MIN_SILENCE:      cfg_next.min_silence      = cfg_wdata[LEN_W-1:0];
                REG_MIN_SILENCE_LONG: cfg_next.min_silence_long = cfg_wdata[LEN_W-1:0];
                REG_MIN_SPEECH:       cfg_next.min_speech       = cfg_wdata[LEN_W-1:0];
                REG_MAX_SPEECH:       cfg_next.max_speech       = cfg_wdata[LEN_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold        <= THRESHOLD_RST;
            cfg_reg.window_samples   <= WINDOW_SAMPLES_RST;
            cfg_reg.min_silence      <= MIN_SILENCE_RST;
            cfg_reg.min_silence_long <= MIN_SILENCE_LONG_RST;
            cfg_reg.min_speech       <= MIN_SPEECH_RST;
            cfg_reg.max_speech       <= MAX_SPEECH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/sst_track.sv =====
// ----------------------------------------------------------------------------
// Speech segment tracker state and decision logic
// Holds the segment state and decides one window or end item per step.
// ----------------------------------------------------------------------------
module sst_track
    import sst_pkg::*;
#(
    parameter int POS_WIDTH  = POS_WIDTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output logic      hit,
    output out_item_t result
);

    localparam int PROB_WIDTH = PROB_W;
    // comparison width wide enough for positions and 32-bit limits
    localparam int CW = (POS_WIDTH > LEN_W) ? POS_WIDTH : LEN_W;
    // 0.15 in the probability format, rounded
    localparam logic [PROB_WIDTH:0] DIP_FIX =
        (PROB_WIDTH + 1)'((15 * (64'd1 << (PROB_WIDTH - 1)) + 50) / 100);
    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    // state registers; a segment is open exactly while speech is tracked
    logic                 seg_open_reg,       seg_open_next;
    logic                 silence_valid_reg,  silence_valid_next;
    logic                 pause_valid_reg,    pause_valid_next;
    logic [POS_WIDTH-1:0] open_start_reg,     open_start_next;
    logic [POS_WIDTH-1:0] position_reg,       position_next;
    logic [POS_WIDTH-1:0] silence_begin_reg,  silence_begin_next;
    logic [POS_WIDTH-1:0] last_pause_end_reg, last_pause_end_next;
    logic [POS_WIDTH-1:0] resume_start_reg,   resume_start_next;

    logic [PROB_WIDTH-1:0] prob;
    logic [PROB_WIDTH-1:0] thr;
    logic                  above;
    logic                  dip_bridged;
    logic [POS_WIDTH-1:0]  win;
    logic [POS_WIDTH:0]    pos_sum;
    logic [POS_WIDTH-1:0]  pos_new;
    logic [POS_WIDTH-1:0]  win_start;
    logic [POS_WIDTH-1:0]  span;
    logic                  too_long;
    logic [POS_WIDTH-1:0]  sil_begin;
    logic [POS_WIDTH-1:0]  gap;
    logic [POS_WIDTH-1:0]  seg_len;

    // position advance with saturation and window start
    assign prob      = PROB_WIDTH'(item.frame_prob);
    assign thr       = PROB_WIDTH'(cfg.threshold);
    assign win       = POS_WIDTH'(cfg.window_samples);
    assign pos_sum   = {1'b0, position_reg} + {1'b0, win};
    assign pos_new   = pos_sum[POS_WIDTH] ? POS_MAX : pos_sum[POS_WIDTH-1:0];
    assign win_start = (pos_new > win) ? (pos_new - win) : '0;

    // threshold and bridged-dip tests
    assign above       = (prob >= thr);
    assign dip_bridged = (({1'b0, prob} + DIP_FIX) >= {1'b0, thr});

    // segment length so far against the forced split limit
    assign span     = (pos_new > open_start_reg) ? (pos_new - open_start_reg) : '0;
    assign too_long = seg_open_reg && (CW'(span) > CW'(cfg.max_speech));

    // silence run measured from its first quiet window
    assign sil_begin = silence_valid_reg ? silence_begin_reg : pos_new;
    assign gap       = (pos_new > sil_begin) ? (pos_new - sil_begin) : '0;
    assign seg_len   = (sil_begin > open_start_reg) ? (sil_begin - open_start_reg) : '0;

    // next state and result for the item in the input register
    always_comb begin
        seg_open_next       = seg_open_reg;
        silence_valid_next  = silence_valid_reg;
        pause_valid_next    = pause_valid_reg;
        open_start_next     = open_start_reg;
        position_next       = position_reg;
        silence_begin_next  = silence_begin_reg;
        last_pause_end_next = last_pause_end_reg;
        resume_start_next   = resume_start_reg;
        hit                 = 1'b0;
        result.seg_start    = SAMPLE_W'(open_start_reg);
        result.seg_end      = item.audio_length;

        if (item.mode == MODE_END) begin
            // close any open segment and clear everything
            hit                 = seg_open_reg;
            seg_open_next       = 1'b0;
            silence_valid_next  = 1'b0;
            pause_valid_next    = 1'b0;
            open_start_next     = '0;
            position_next       = '0;
            silence_begin_next  = '0;
            last_pause_end_next = '0;
            resume_start_next   = '0;
        end else begin
            position_next = pos_new;
            if (above) begin
                // speech window: end any silence run, open a segment if idle
                if (silence_valid_reg) begin
                    silence_valid_next = 1'b0;
                    silence_begin_next = '0;
                    if (pause_valid_reg && (resume_start_reg < last_pause_end_reg)) begin
                        resume_start_next = win_start;
                    end
                end
                if (!seg_open_reg) begin
                    seg_open_next   = 1'b1;
                    open_start_next = win_start;
                end
            end else if (too_long) begin
                // forced split, at the last long pause when there is one
                hit                 = 1'b1;
                seg_open_next       = 1'b0;
                silence_valid_next  = 1'b0;
                pause_valid_next    = 1'b0;
                open_start_next     = '0;
                silence_begin_next  = '0;
                last_pause_end_next = '0;
                resume_start_next   = '0;
                if (pause_valid_reg) begin
                    result.seg_end = SAMPLE_W'(last_pause_end_reg);
                    if (resume_start_reg >= last_pause_end_reg) begin
                        seg_open_next   = 1'b1;
                        open_start_next = resume_start_reg;
                    end
                end else begin
                    result.seg_end = SAMPLE_W'(pos_new);
                end
            end else if (!dip_bridged && seg_open_reg) begin
                // deep silence inside a segment
                silence_valid_next = 1'b1;
                silence_begin_next = sil_begin;
                if (CW'(gap) > CW'(cfg.min_silence_long)) begin
                    last_pause_end_next = sil_begin;
                    pause_valid_next    = 1'b1;
                end
                if (CW'(gap) >= CW'(cfg.min_silence)) begin
                    seg_open_next       = 1'b0;
                    silence_valid_next  = 1'b0;
                    pause_valid_next    = 1'b0;
                    open_start_next     = '0;
                    silence_begin_next  = '0;
                    last_pause_end_next = '0;
                    resume_start_next   = '0;
                    hit                 = (CW'(seg_len) > CW'(cfg.min_speech));
                    result.seg_end      = SAMPLE_W'(sil_begin);
                end
            end
        end
    end

    // state update, once per processed transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_open_reg       <= 1'b0;
            silence_valid_reg  <= 1'b0;
            pause_valid_reg    <= 1'b0;
            open_start_reg     <= '0;
            position_reg       <= '0;
            silence_begin_reg  <= '0;
            last_pause_end_reg <= '0;
            resume_start_reg   <= '0;
        end else if (step) begin
            seg_open_reg       <= seg_open_next;
            silence_valid_reg  <= silence_valid_next;
            pause_valid_reg    <= pause_valid_next;
            open_start_reg     <= open_start_next;
            position_reg       <= position_next;
            silence_begin_reg  <= silence_begin_next;
            last_pause_end_reg <= last_pause_end_next;
            resume_start_reg   <= resume_start_next;
        end
    end

`include "speech_segment_tracker_unit_assert.svh"

    // silence and pause tracking only exist inside an open segment
    `SST_ASSERT_NOW(a_silence_in_seg, aclk, aresetn, silence_valid_reg || pause_valid_reg, seg_open_reg, "silence state outside segment")
    // an end transaction leaves the tracker fully idle
    `SST_ASSERT_NEXT(a_end_clears, aclk, aresetn, step && (item.mode == MODE_END), !seg_open_reg && (position_reg == '0), "end transaction did not clear state")
    // window transactions never move the position backward
    `SST_ASSERT_NEXT(a_pos_mono, aclk, aresetn, step && (item.mode == MODE_WINDOW), position_reg >= $past(position_reg), "position moved backward")

endmodule

// ===== bench/sst_segment_checker.sv =====
// ----------------------------------------------------------------------------
// Speech segment tracker checker
// Watches the item, result and register ports, runs its own copy of the
// segment tracking rules and compares each returned segment, field by field,
// with the oldest segment it predicted.
// ----------------------------------------------------------------------------
module sst_segment_checker
    import sst_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  in_item_t               s_item,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  out_item_t              m_item,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int unsigned            mismatch_count,
    output int unsigned            pending_count
);

    localparam bit [63:0] POS_CEIL   = (64'd1 << POS_WIDTH_DEF) - 64'd1;
    // 0.15 in the probability format, rounded
    localparam bit [63:0] DIP_MARGIN =
        (64'd15 * (64'd1 << (PROB_WIDTH_DEF - 1)) + 64'd50) / 64'd100;
    localparam int unsigned REPORT_LIMIT = 10;

    // register copies
    bit [63:0] thr_q;
    bit [63:0] win_q;
    bit [63:0] quiet_min;
    bit [63:0] pause_min;
    bit [63:0] speech_min;
    bit [63:0] speech_max;

    // tracker state
    bit        talking;
    bit        seg_live;
    bit        quiet_seen;
    bit        pause_seen;
    bit [63:0] seg_head;
    bit [63:0] pos;
    bit [63:0] quiet_from;
    bit [63:0] pause_end;
    bit [63:0] resume_at;

    out_item_t   expected_segments[$];
    int unsigned fault_count;

    function automatic bit [63:0] clamp_diff(input bit [63:0] a, input bit [63:0] b);
        return (a > b) ? a - b : 64'd0;
    endfunction

    // forget the current segment, keep the position
    function automatic void drop_segment();
        talking    = 1'b0;
        seg_live   = 1'b0;
        seg_head   = '0;
        pause_seen = 1'b0;
        pause_end  = '0;
        resume_at  = '0;
        quiet_seen = 1'b0;
        quiet_from = '0;
    endfunction

    // apply one transaction to the tracker; returns 1 when a segment comes out
    function automatic bit advance_tracker(input in_item_t item, output out_item_t seg);
        bit [63:0] prob;
        bit [63:0] win_start;
        bit [63:0] gap;
        bit [63:0] cut;
        bit [63:0] restart;
        bit [63:0] from;
        bit [63:0] upto;
        bit        made;
        prob = 64'(item.frame_prob);
        seg  = '0;
        made = 1'b0;

        // end of audio: close any open segment, clear everything
        if (item.mode == MODE_END) begin
            if (seg_live) begin
                seg.seg_start = seg_head[SAMPLE_W-1:0];
                seg.seg_end   = item.audio_length;
                made          = 1'b1;
            end
            drop_segment();
            pos = '0;
            return made;
        end

        // saturating position advance
        pos       = (POS_CEIL - pos < win_q) ? POS_CEIL : pos + win_q;
        win_start = clamp_diff(pos, win_q);

        // speech window
        if (prob >= thr_q) begin
            if (quiet_seen) begin
                quiet_seen = 1'b0;
                quiet_from = '0;
                if (pause_seen && resume_at < pause_end)
                    resume_at = win_start;
            end
            if (!talking) begin
                talking  = 1'b1;
                seg_live = 1'b1;
                seg_head = win_start;
            end
            return 1'b0;
        end

        // overlong segment: split at the last long pause or at the position
        if (talking && clamp_diff(pos, seg_head) > speech_max) begin
            if (pause_seen) begin
                cut           = pause_end;
                restart       = resume_at;
                seg.seg_start = seg_head[SAMPLE_W-1:0];
                seg.seg_end   = cut[SAMPLE_W-1:0];
                drop_segment();
                if (restart >= cut) begin
                    talking  = 1'b1;
                    seg_live = 1'b1;
                    seg_head = restart;
                end
            end else begin
                seg.seg_start = seg_head[SAMPLE_W-1:0];
                seg.seg_end   = pos[SAMPLE_W-1:0];
                drop_segment();
            end
            return 1'b1;
        end

        // shallow dip is bridged
        if (prob + DIP_MARGIN >= thr_q)
            return 1'b0;

        // deep silence
        if (talking) begin
            if (!quiet_seen) begin
                quiet_seen = 1'b1;
                quiet_from = pos;
            end
            gap = clamp_diff(pos, quiet_from);
            if (gap > pause_min) begin
                pause_end  = quiet_from;
                pause_seen = 1'b1;
            end
            if (gap >= quiet_min) begin
                from = seg_head;
                upto = quiet_from;
                drop_segment();
                if (clamp_diff(upto, from) > speech_min) begin
                    seg.seg_start = from[SAMPLE_W-1:0];
                    seg.seg_end   = upto[SAMPLE_W-1:0];
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    task automatic log_fault(input string what);
        if (fault_count < REPORT_LIMIT)
            $display("[%0t] segment check: %s", $time, what);
        fault_count++;
    endtask

    // compare, then take register writes, then predict
    always @(posedge aclk) begin : watch
        out_item_t want;
        out_item_t seg;
        if (!aresetn) begin
            thr_q      = 64'(THRESHOLD_RST);
            win_q      = 64'(WINDOW_SAMPLES_RST);
            quiet_min  = 64'(MIN_SILENCE_RST);
            pause_min  = 64'(MIN_SILENCE_LONG_RST);
            speech_min = 64'(MIN_SPEECH_RST);
            speech_max = 64'(MAX_SPEECH_RST);
            drop_segment();
            pos = '0;
            expected_segments.delete();
            fault_count = 0;
        end else begin
            // result transaction against the oldest expectation
            if (m_valid && m_ready) begin
                if (expected_segments.size() == 0) begin
                    log_fault($sformatf("unexpected segment start %0d end %0d",
                                        m_item.seg_start, m_item.seg_end));
                end else begin
                    want = expected_segments.pop_front();
                    if (m_item.seg_start !== want.seg_start ||
                        m_item.seg_end !== want.seg_end)
                        log_fault($sformatf("start exp %0d got %0d, end exp %0d got %0d",
                                            want.seg_start, m_item.seg_start,
                                            want.seg_end, m_item.seg_end));
                end
            end

            // register write
            if (cfg_we) begin
                case (cfg_index)
                    REG_THRESHOLD:        thr_q      = 64'(cfg_wdata[THR_W-1:0]);
                    REG_WINDOW_SAMPLES:   win_q      = 64'(cfg_wdata[WIN_W-1:0]);
                    REG_MIN_SILENCE:      quiet_min  = 64'(cfg_wdata[LEN_W-1:0]);
                    REG_MIN_SILENCE_LONG: pause_min  = 64'(cfg_wdata[LEN_W-1:0]);
                    REG_MIN_SPEECH:       speech_min = 64'(cfg_wdata[LEN_W-1:0]);
                    REG_MAX_SPEECH:       speech_max = 64'(cfg_wdata[LEN_W-1:0]);
                    default: ;
                endcase
            end

            // input transaction
            if (s_valid && s_ready) begin
                if (advance_tracker(s_item, seg))
                    expected_segments = {expected_segments, seg};
            end
        end
        mismatch_count <= fault_count;
        pending_count  <= expected_segments.size();
    end

endmodule

// ===== bench/speech_segment_tracker_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Speech segment tracker testbench
// Drives directed and random probability streams through the tracker under
// a series of register settings, with random idling on both channels and a
// long result back-pressure stretch.
// The checker beside the block predicts and compares every segment.
// ----------------------------------------------------------------------------
module speech_segment_tracker_unit_tb;
    import sst_pkg::*;

    localparam int          HALF_PERIOD   = 6;
    localparam int          RESET_CYCLES  = 12;
    localparam int unsigned ITEM_TARGET   = 1150;
    localparam int unsigned RESULT_TARGET = 60;
    localparam int unsigned PHASE_ITEMS   = 120;
    localparam int unsigned MAX_PHASES    = 40;
    localparam int unsigned IDLE_PCT      = 6;
    localparam int          HOLD_CYCLES   = 150;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          CYCLE_LIMIT   = 200_000;
    localparam int unsigned PROB_FULL     = 32768;
    localparam int unsigned BRIDGE_MARGIN = 4915;

    typedef enum {LVL_SPEECH, LVL_DIP, LVL_QUIET, LVL_NOISE} prob_level_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_item    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_item;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_THRESHOLD;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int unsigned mismatch_count;
    int unsigned pending_count;
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned hold_asks    = 0;
    int unsigned holds_served = 0;
    int unsigned cur_thr      = THRESHOLD_RST;
    bit          steady       = 1'b0;

    always #HALF_PERIOD aclk = ~aclk;

    speech_segment_tracker_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sst_segment_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item         (s_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_item         (m_item),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // probability drawn from a band relative to the current threshold
    function automatic logic [PROB_W-1:0] pick_prob(input prob_level_t lvl);
        int unsigned dip_floor;
        dip_floor = (cur_thr > BRIDGE_MARGIN) ? cur_thr - BRIDGE_MARGIN : 0;
        if (lvl == LVL_NOISE || cur_thr == 0)
            return PROB_W'($urandom_range(0, PROB_FULL));
        case (lvl)
            LVL_SPEECH: return PROB_W'($urandom_range(cur_thr, PROB_FULL));
            LVL_DIP:    return PROB_W'($urandom_range(dip_floor, cur_thr - 1));
            default: begin
                if (cur_thr > BRIDGE_MARGIN)
                    return PROB_W'($urandom_range(0, dip_floor - 1));
                return PROB_W'($urandom_range(0, cur_thr - 1));
            end
        endcase
    endfunction

    // window transaction; the unused length field carries noise
    function automatic in_item_t window_item(input logic [PROB_W-1:0] prob);
        in_item_t item;
        item.mode         = MODE_WINDOW;
        item.frame_prob   = prob;
        item.audio_length = $urandom();
        return item;
    endfunction

    // end of audio transaction; the unused probability carries noise
    function automatic in_item_t end_item(input logic [SAMPLE_W-1:0] len);
        in_item_t item;
        item.mode         = MODE_END;
        item.frame_prob   = PROB_W'($urandom_range(0, PROB_FULL));
        item.audio_length = len;
        return item;
    endfunction

    // offer one transaction, with a random idle gap ahead of it
    task automatic send_item(input in_item_t item);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // stop offering and wait until every expected segment has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic set_config(input bit [31:0] thr, input bit [31:0] win,
                              input bit [31:0] quiet, input bit [31:0] pause,
                              input bit [31:0] shortest, input bit [31:0] longest);
        wait_idle();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_WINDOW_SAMPLES, win);
        write_reg(REG_MIN_SILENCE, quiet);
        write_reg(REG_MIN_SILENCE_LONG, pause);
        write_reg(REG_MIN_SPEECH, shortest);
        write_reg(REG_MAX_SPEECH, longest);
        cfg_we  <= 1'b0;
        cur_thr = thr;
    endtask

    // mostly speech bursts followed by silence, with noise and end items
    task automatic random_phase(input int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                case ($urandom_range(0, 3))
                    0:       send_item(end_item(32'd0));
                    1:       send_item(end_item(32'hFFFF_FFFF));
                    default: send_item(end_item($urandom()));
                endcase
            end else if (pick < 12) begin
                send_item(window_item(pick_prob(LVL_NOISE)));
            end else begin
                repeat ($urandom_range(1, 16))
                    send_item(window_item(pick_prob(
                        ($urandom_range(0, 6) == 0) ? LVL_DIP : LVL_SPEECH)));
                repeat ($urandom_range(1, 10))
                    send_item(window_item(pick_prob(
                        ($urandom_range(0, 7) == 0) ? LVL_DIP : LVL_QUIET)));
            end
        end
    endtask

    // result side: random back-pressure and one long hold when asked
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                results_seen++;
            if (holds_served != hold_asks) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("speech_segment_tracker_unit regression: fail");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase;
        int unsigned win;
        int unsigned quiet;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset settings: end with nothing open
        send_item(end_item(32'd0));
        // segment with bridged dips, closed by silence
        repeat (6) send_item(window_item(PROB_W'(PROB_FULL)));
        send_item(window_item(PROB_W'(THRESHOLD_RST - BRIDGE_MARGIN)));
        send_item(window_item(THRESHOLD_RST - 16'd1));
        send_item(window_item(THRESHOLD_RST));
        repeat (5) send_item(window_item(16'd0));
        // segment too short to report
        send_item(window_item(THRESHOLD_RST));
        repeat (5) send_item(window_item(16'd0));
        // open segment closed by the end item
        send_item(window_item(PROB_W'(PROB_FULL)));
        send_item(end_item(32'hFFFF_FFFF));
        wait_idle();

        // reset settings, no idling at all
        steady = 1'b1;
        random_phase(PHASE_ITEMS);
        steady = 1'b0;

        // one-sample windows, pauses shorter than the end-of-segment silence
        set_config(20000, 1, 6, 2, 4, 20);
        random_phase(PHASE_ITEMS);

        // low threshold: every dip bridged, segments end by splitting or at an end item
        set_config(3000, 4096, 0, 0, 0, 40000);
        random_phase(PHASE_ITEMS);

        // zero threshold: everything is speech
        set_config(0, 100, 300, 100, 0, 2000);
        random_phase(PHASE_ITEMS);

        // full threshold, immediate splits, result side held off
        set_config(PROB_FULL, 4096, 0, 0, 0, 0);
        steady = 1'b1;
        hold_asks++;
        random_phase(PHASE_ITEMS);
        steady = 1'b0;

        // silence never ends a segment, only the split or an end item does
        set_config(14000, 4096, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        random_phase(PHASE_ITEMS);

        set_config(18000, 1, 1, 0, 0, 32'hFFFF_FFFF);
        random_phase(PHASE_ITEMS);

        // random settings until enough traffic and segments
        phase = 0;
        while ((items_sent < ITEM_TARGET || results_seen < RESULT_TARGET) &&
               phase < MAX_PHASES) begin
            win   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 64)
                                                : $urandom_range(1, 4096);
            quiet = win * $urandom_range(0, 8) + $urandom_range(0, win);
            set_config(($urandom_range(0, 4) == 0) ? $urandom_range(0, PROB_FULL)
                                                   : $urandom_range(6000, 30000),
                       win, quiet, $urandom_range(0, quiet),
                       win * $urandom_range(0, 12),
                       ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                   : win * $urandom_range(1, 30));
            random_phase(PHASE_ITEMS);
            phase++;
        end

        // close whatever is still open
        send_item(end_item(32'hFFFF_FFFF));
        wait_idle();

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("speech_segment_tracker_unit regression: pass");
        end else begin
            $display("speech_segment_tracker_unit regression: fail");
        end
        $finish;
    end

endmodule
